### rtl/core/slr_pkg.sv
package slr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 16;
    localparam int STEP_W    = 22;
    localparam int PHASE_W   = 22;
    localparam int SUM_W     = PHASE_W + 1;
    localparam int MAX_RUN   = 32;
    localparam int RUN_W     = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    localparam logic [SUM_W-1:0]   PHASE_ONE  = SUM_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);
    localparam logic [RUN_W-1:0]   RUN_LAST   = RUN_W'(MAX_RUN - 1);
    localparam logic [PROD_W-1:0]  TRUNC_BIAS = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;

    // one queued frame; prime marks the very first frame after reset
    typedef struct packed {
        t_sample left;
        t_sample right;
        logic    prime;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic emitting;
    } t_back_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CHECK,
        BK_EMIT
    } t_back_state;

    // prev + trunc(prod / 2^FRAC_BITS), rounding toward zero
    function automatic t_sample interp_fin(input t_prod prod, input t_sample prev);
        t_prod biased;
        t_prod shifted;
        biased  = prod[PROD_W-1] ? t_prod'(prod + TRUNC_BIAS) : prod;
        shifted = biased >>> FRAC_BITS;
        return t_sample'(prev + t_sample'(shifted[SAMPLE_W-1:0]));
    endfunction

    // end-of-run phase: drop one, saturating at zero
    function automatic logic [PHASE_W-1:0] phase_wrap(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] d;
        d = x - PHASE_ONE;
        return (x >= PHASE_ONE) ? d[PHASE_W-1:0] : '0;
    endfunction

endpackage

### rtl/core/stereo_linear_resampler.sv
// Flow: the queue takes an accepted input beat; the back end reads it while idle, then
//   registers the products and rounds and adds them into the result register (read,
//   multiply, then round and add); further results of the run repeat the last two steps,
//   and stall while the result register is full and pop is low.
// A frame's run (at most 32 results, none for priming) ends before the next frame is read.
// Reset: synchronous, active low; clears phase, previous frame, priming flag and queues,
//   and sets the phase step to 65536 (unity ratio).
module stereo_linear_resampler
    import slr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input frame queue side
    input  logic                push,
    output logic                full,
    input  logic signed [SAMPLE_W-1:0] i_left_in,
    input  logic signed [SAMPLE_W-1:0] i_right_in,
    // result queue side
    output logic                empty,
    input  logic                pop,
    output logic signed [SAMPLE_W-1:0] o_left_out,
    output logic signed [SAMPLE_W-1:0] o_right_out,
    output logic                o_last_of_run,
    // phase step register write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [STEP_W-1:0]   i_cfg_phase_step
);

    t_q_stat    q_stat;
    t_item      q_wr_item;
    t_item      q_rd_item;
    logic       q_wr;
    logic       q_rd;
    t_back_stat bk_stat;
    logic       cfg_wr;

    // Register writes are to arrive only while idle; the block does not enforce this. The port never stalls.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign full        = q_stat.full;

    // Front: takes input beats and tags the first frame after reset as priming.
    slr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_left_in  (i_left_in),
        .i_right_in (i_right_in),
        .i_q_stat   (q_stat),
        .o_q_wr     (q_wr),
        .o_q_item   (q_wr_item)
    );

    // Two-entry queue decouples the front from the interpolating back end.
    slr_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_item (q_wr_item),
        .i_rd      (q_rd),
        .o_rd_item (q_rd_item),
        .o_stat    (q_stat)
    );

    // Back: phase accumulator, one interpolated frame per run step, result register.
    slr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr      (cfg_wr),
        .i_cfg_step    (i_cfg_phase_step),
        .i_q_stat      (q_stat),
        .i_q_item      (q_rd_item),
        .o_q_rd        (q_rd),
        .pop           (pop),
        .empty         (empty),
        .o_left_out    (o_left_out),
        .o_right_out   (o_right_out),
        .o_last_of_run (o_last_of_run),
        .o_stat        (bk_stat)
    );

    // the queue can never report full and empty together
    a_q_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // a waiting beat that does not close its run means the back end is still mid-run
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last_of_run) |-> bk_stat.busy)
        else $error("non-final result with back end idle");

    // the back end only reads the queue when it holds an entry
    a_rd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !q_stat.empty)
        else $error("queue read while empty");

    // a result is computed only after its product was registered
    a_emit_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(bk_stat.emitting) |-> $past(bk_stat.busy))
        else $error("emit entered without check step");

endmodule

### rtl/core/slr_front.sv
module slr_front
    import slr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    input  t_sample i_left_in,
    input  t_sample i_right_in,
    input  t_q_stat i_q_stat,
    output logic    o_q_wr,
    output t_item   o_q_item
);

    logic r_primed;
    logic n_primed;

    always_comb begin
        o_q_wr         = push && !i_q_stat.full;
        o_q_item.left  = i_left_in;
        o_q_item.right = i_right_in;
        o_q_item.prime = !r_primed;
        n_primed       = r_primed || o_q_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else begin
            r_primed <= n_primed;
        end
    end

endmodule

### rtl/core/slr_queue.sv
module slr_queue
    import slr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_item   i_wr_item,
    input  logic    i_rd,
    output t_item   o_rd_item,
    output t_q_stat o_stat
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_cnt;
    logic              wr_en;
    logic              rd_en;

    always_comb begin
        o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
        o_stat.empty = (r_cnt == '0);
        wr_en        = i_wr && !o_stat.full;
        rd_en        = i_rd && !o_stat.empty;
        o_rd_item    = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= Q_AW'(r_wp + 1'b1);
            end
            if (rd_en) begin
                r_rp <= Q_AW'(r_rp + 1'b1);
            end
            r_cnt <= Q_CW'(r_cnt + Q_CW'(wr_en) - Q_CW'(rd_en));
        end
    end

endmodule

### rtl/core/slr_back.sv
module slr_back
    import slr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr,
    input  logic [STEP_W-1:0]   i_cfg_step,
    input  t_q_stat             i_q_stat,
    input  t_item               i_q_item,
    output logic                o_q_rd,
    input  logic                pop,
    output logic                empty,
    output t_sample             o_left_out,
    output t_sample             o_right_out,
    output logic                o_last_of_run,
    output t_back_stat          o_stat
);

    t_back_state         r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [RUN_W-1:0]    r_n, n_n;
    t_sample             r_prev_l, n_prev_l;
    t_sample             r_prev_r, n_prev_r;
    t_sample             r_cur_l, n_cur_l;
    t_sample             r_cur_r, n_cur_r;
    t_prod               r_prod_l, n_prod_l;
    t_prod               r_prod_r, n_prod_r;
    logic                r_out_valid, n_out_valid;
    t_sample             r_out_l, n_out_l;
    t_sample             r_out_r, n_out_r;
    logic                r_out_last, n_out_last;

    logic                out_free;
    logic [SUM_W-1:0]    sum;
    logic                last;
    logic signed [DIFF_W-1:0] diff_l;
    logic signed [DIFF_W-1:0] diff_r;
    logic signed [DIFF_W-1:0] frac;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_phase     = r_phase;
        n_n         = r_n;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_prod_l    = r_prod_l;
        n_prod_r    = r_prod_r;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_last  = r_out_last;
        o_q_rd      = 1'b0;

        n_out_valid = r_out_valid && !pop;
        out_free    = !r_out_valid || pop;
        sum         = SUM_W'(r_phase) + SUM_W'(r_step);
        last        = (sum >= PHASE_ONE) || (r_n == RUN_LAST);
        diff_l      = DIFF_W'(r_cur_l) - DIFF_W'(r_prev_l);
        diff_r      = DIFF_W'(r_cur_r) - DIFF_W'(r_prev_r);
        frac        = $signed({1'b0, r_phase[FRAC_BITS-1:0]});

        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_rd  = 1'b1;
                    n_cur_l = i_q_item.left;
                    n_cur_r = i_q_item.right;
                    if (i_q_item.prime) begin
                        n_prev_l = i_q_item.left;
                        n_prev_r = i_q_item.right;
                    end else begin
                        n_n     = '0;
                        n_state = BK_CHECK;
                    end
                end
            end
            BK_CHECK: begin
                if (SUM_W'(r_phase) < PHASE_ONE) begin
                    n_prod_l = t_prod'(diff_l) * t_prod'(frac);
                    n_prod_r = t_prod'(diff_r) * t_prod'(frac);
                    n_state  = BK_EMIT;
                end else begin
                    // phase already at or past one: empty run
                    n_phase  = phase_wrap(SUM_W'(r_phase));
                    n_prev_l = r_cur_l;
                    n_prev_r = r_cur_r;
                    n_state  = BK_IDLE;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_l     = interp_fin(r_prod_l, r_prev_l);
                    n_out_r     = interp_fin(r_prod_r, r_prev_r);
                    n_out_last  = last;
                    n_n         = RUN_W'(r_n + 1'b1);
                    if (last) begin
                        n_phase  = phase_wrap(sum);
                        n_prev_l = r_cur_l;
                        n_prev_r = r_cur_r;
                        n_state  = BK_IDLE;
                    end else begin
                        n_phase = sum[PHASE_W-1:0];
                        n_state = BK_CHECK;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (i_cfg_wr) begin
            n_step  = i_cfg_step;
            n_phase = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= STEP_RESET;
            r_phase     <= '0;
            r_n         <= '0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_n         <= n_n;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_l    <= n_cur_l;
        r_cur_r    <= n_cur_r;
        r_prod_l   <= n_prod_l;
        r_prod_r   <= n_prod_r;
        r_out_l    <= n_out_l;
        r_out_r    <= n_out_r;
        r_out_last <= n_out_last;
    end

    always_comb begin
        empty           = !r_out_valid;
        o_left_out      = r_out_l;
        o_right_out     = r_out_r;
        o_last_of_run   = r_out_last;
        o_stat.busy     = (r_state != BK_IDLE);
        o_stat.emitting = (r_state == BK_EMIT);
    end

endmodule
